FILE: design/spt_pkg.sv
// Package for the sorted priority table: defaults, field widths, codes
// and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package spt_pkg;

  // default sizes of the table
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned BATCH_DEF     = 4;
  localparam int unsigned PRIO_BITS_DEF = 16;

  // fixed widths of the stream fields
  localparam int unsigned PRIO_REQ_W = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned TOP_W      = 16;
  localparam int unsigned REMOVED_W  = 3;
  localparam int unsigned OUT_DATA_W = 32;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic capture;  // latch the accepted command beat
    logic update;   // apply the command to the table, load the result
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: design/sorted_priority_table_top.sv
// Top level of the sorted priority table: stream ports, controller and
// datapath. Depends on spt_pkg, spt_ctrl and spt_datapath.
//
//  channel  | dir | beat contents
//  ---------+-----+----------------------------------------------------
//  s_axis   | in  | tuser: command; tdata: priority_req
//  m_axis   | out | tdata: status, occupancy, top_priority, removed_count
//
// A command beat is captured, then applied to the table in the execute
// state once the result register is free, and its result loaded into the
// output register. The table update compares all slots in parallel.
// A new command is taken in the cycle after the update, even while the
// previous result waits. A stalled result holds the update of the next
// command. Reset empties the table at once; no clearing pass.
`default_nettype none

module sorted_priority_table_top
  import spt_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned BATCH     = BATCH_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [PRIO_REQ_W-1:0] s_axis_tdata,  // [15:0] priority_req
  input  wire logic                  s_axis_tuser,  // [0] command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [1:0] status, [6:2] occupancy, [22:7] top_priority,
  // [25:23] removed_count, [31:26] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  ctrl_cmd_t cmd;

  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  spt_datapath #(
    .DEPTH     (DEPTH),
    .BATCH     (BATCH),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_cmd_i   (s_axis_tuser),
    .in_prio_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

  // an update never overwrites a result that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result overwritten while stalled");

  // one command in flight: no beat taken right after an accept
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command accepted during update");

  // a result appears only after a table update
  a_valid_after_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.update))
    else $error("result valid without an update");

endmodule

`default_nettype wire

FILE: design/spt_datapath.sv
// Datapath of the sorted priority table: slot register chain, occupancy
// counter, insert and batch-remove logic, result register.
// Depends on spt_pkg.
`default_nettype none

module spt_datapath
  import spt_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned BATCH     = BATCH_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_cmd_t               cmd_i,
  input  wire logic                    in_cmd_i,
  input  wire logic [PRIO_REQ_W-1:0]   in_prio_i,
  output logic      [OUT_DATA_W-1:0]   out_data_o
);

  localparam int unsigned UW = $clog2(DEPTH + 1);
  localparam int unsigned RW = $clog2(BATCH + 1);
  localparam int unsigned XD = DEPTH + BATCH;
  localparam int unsigned PADW = OUT_DATA_W - STATUS_W - OCC_W - TOP_W - REMOVED_W;

  logic [PRIO_BITS-1:0] slots_q [DEPTH];
  logic [PRIO_BITS-1:0] slots_d [DEPTH];
  logic [PRIO_BITS-1:0] ins_v   [DEPTH];
  logic [PRIO_BITS-1:0] deq_v   [DEPTH];
  logic [PRIO_BITS-1:0] ext_v   [XD];
  logic [DEPTH-1:0]     lt_v;
  logic [UW-1:0]        used_q, used_d;
  logic                 cmd_q;
  logic [PRIO_BITS-1:0] prio_q, prio_m;
  logic [RW-1:0]        rm;
  logic [RW-1:0]        rm_d;
  logic [STATUS_W-1:0]  status_d;
  logic                 full;
  logic [OUT_DATA_W-1:0] out_q;

  // mask or widen the request to the table width
  if (PRIO_BITS >= PRIO_REQ_W) begin : g_prio_wide
    assign prio_m = PRIO_BITS'(in_prio_i);
  end else begin : g_prio_narrow
    assign prio_m = in_prio_i[PRIO_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= in_cmd_i;
      prio_q <= prio_m;
    end
  end

  assign full = (used_q == UW'(DEPTH));
  assign rm   = (32'(used_q) < BATCH) ? RW'(used_q) : RW'(BATCH);

  // table padded with empty slots so a shifted read never runs off the end
  for (genvar j = 0; j < XD; j++) begin : g_ext
    if (j < DEPTH) begin : g_in
      assign ext_v[j] = slots_q[j];
    end else begin : g_pad
      assign ext_v[j] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_v[i] = (slots_q[i] < prio_q);
    end
    // new entry lands at the first slot below it, lower ones move down one
    for (int i = 0; i < DEPTH; i++) begin
      if (!lt_v[i]) begin
        ins_v[i] = slots_q[i];
      end else if (i == 0) begin
        ins_v[i] = prio_q;
      end else if (!lt_v[i-1]) begin
        ins_v[i] = prio_q;
      end else begin
        ins_v[i] = slots_q[i-1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      deq_v[i] = '0;
      for (int k = 0; k <= BATCH; k++) begin
        if (rm == RW'(k)) begin
          deq_v[i] = ext_v[i+k];
        end
      end
    end
  end

  always_comb begin
    slots_d  = slots_q;
    used_d   = used_q;
    status_d = ST_DONE;
    rm_d     = '0;
    if (cmd_q == CMD_ENQ) begin
      if (prio_q == '0) begin
        status_d = ST_ZERO;
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        slots_d = ins_v;
        used_d  = used_q + UW'(1);
      end
    end else begin
      slots_d = deq_v;
      used_d  = used_q - UW'(rm);
      rm_d    = rm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        slots_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      used_q  <= used_d;
      slots_q <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_q <= {PADW'(0), REMOVED_W'(rm_d), TOP_W'(slots_d[0]),
                OCC_W'(used_d), status_d};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: design/spt_ctrl.sv
// Controller of the sorted priority table: command sequencing and the
// result valid flag.
// Depends on spt_pkg.
`default_nettype none

module spt_ctrl
  import spt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
